### rtl/sit_pkg.sv
// Shared types and helpers for the segment intersection test pipeline.
// No dependencies; used by sit_lane and segment_intersection_test_unit.
package sit_pkg;

   // Side of a point relative to a directed segment
   typedef enum logic [1:0] {
      CLS_ZERO = 2'b00,
      CLS_POS  = 2'b01,
      CLS_NEG  = 2'b10
   } class_type;

   // Per-stage load enables handed from the pipeline control to each lane
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } lane_en_type;

   // Product of two classifications is zero or negative
   function automatic logic pair_ok(class_type a, class_type b);
      return (a == CLS_ZERO) || (b == CLS_ZERO) || (a != b);
   endfunction

endpackage

### rtl/sit_lane.sv
// One relative-CCW classification lane: differences, products, sign decision.
// Depends on sit_pkg (class_type, lane_en_type).
module sit_lane #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  sit_pkg::lane_en_type         en,
   input  logic signed [COORD_BITS-1:0] sx,
   input  logic signed [COORD_BITS-1:0] sy,
   input  logic signed [COORD_BITS-1:0] ex,
   input  logic signed [COORD_BITS-1:0] ey,
   input  logic signed [COORD_BITS-1:0] qx,
   input  logic signed [COORD_BITS-1:0] qy,
   output sit_pkg::class_type           cls
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   // stage 1: differences
   logic signed [DW-1:0] dx_in, dy_in, px_in, py_in, bx_in, by_in;
   logic signed [DW-1:0] dx_ff, dy_ff, px_ff, py_ff, bx_ff, by_ff;

   assign dx_in = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
   assign dy_in = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
   assign px_in = {qx[COORD_BITS-1], qx} - {sx[COORD_BITS-1], sx};
   assign py_in = {qy[COORD_BITS-1], qy} - {sy[COORD_BITS-1], sy};
   // offset of the point from the segment end, for the beyond-end test
   assign bx_in = {qx[COORD_BITS-1], qx} - {ex[COORD_BITS-1], ex};
   assign by_in = {qy[COORD_BITS-1], qy} - {ey[COORD_BITS-1], ey};

   always_ff @(posedge clock) begin
      if (en.s1) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         px_ff <= px_in;
         py_ff <= py_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
      end
   end

   // stage 2: six exact products
   logic signed [PW-1:0] pxdy_in, pydx_in, pxdx_in, pydy_in, bxdx_in, bydy_in;
   logic signed [PW-1:0] pxdy_ff, pydx_ff, pxdx_ff, pydy_ff, bxdx_ff, bydy_ff;

   assign pxdy_in = PW'(px_ff) * PW'(dy_ff);
   assign pydx_in = PW'(py_ff) * PW'(dx_ff);
   assign pxdx_in = PW'(px_ff) * PW'(dx_ff);
   assign pydy_in = PW'(py_ff) * PW'(dy_ff);
   assign bxdx_in = PW'(bx_ff) * PW'(dx_ff);
   assign bydy_in = PW'(by_ff) * PW'(dy_ff);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         pxdy_ff <= pxdy_in;
         pydx_ff <= pydx_in;
         pxdx_ff <= pxdx_in;
         pydy_ff <= pydy_in;
         bxdx_ff <= bxdx_in;
         bydy_ff <= bydy_in;
      end
   end

   // stage 3: cross product, projection and reverse projection signs
   logic signed [SW-1:0] cross_sum, dot, beyond;
   sit_pkg::class_type   cls_in;
   sit_pkg::class_type   cls_ff;

   assign cross_sum = SW'(pxdy_ff) - SW'(pydx_ff);
   assign dot       = SW'(pxdx_ff) + SW'(pydy_ff);
   assign beyond    = SW'(bxdx_ff) + SW'(bydy_ff);

   always_comb begin
      if (cross_sum != '0) begin
         cls_in = cross_sum[SW-1] ? sit_pkg::CLS_NEG : sit_pkg::CLS_POS;
      end else if (dot[SW-1]) begin
         cls_in = sit_pkg::CLS_NEG;   // collinear, before the start
      end else if (dot == '0) begin
         cls_in = sit_pkg::CLS_ZERO;
      end else if (!beyond[SW-1] && (beyond != '0)) begin
         cls_in = sit_pkg::CLS_POS;   // collinear, past the end
      end else begin
         cls_in = sit_pkg::CLS_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         cls_ff <= cls_in;
      end
   end

   assign cls = cls_ff;

endmodule

### rtl/segment_intersection_test_unit.sv
// Top level of the segment intersection test: pipeline control and result stage.
// Depends on sit_pkg and sit_lane (four classification lanes).
//
//  channel | direction | ports                                   | handshake
//  req     | in        | req_{a,b}{x,y}_{start,end}               | req_valid / req_ready
//  rsp     | out       | rsp_intersects                          | rsp_valid / rsp_ready
//
// One request per cycle while the output is not stalled; the result passes through
// four register stages: differences, multipliers, sign decision, combine/output.
// Reset clears the stage valid bits only; data registers are not reset.
// A stalled output fills bubbles first; only a full pipeline drops req_ready.
module segment_intersection_test_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_ax_start,
   input  logic signed [COORD_BITS-1:0] req_ay_start,
   input  logic signed [COORD_BITS-1:0] req_ax_end,
   input  logic signed [COORD_BITS-1:0] req_ay_end,
   input  logic signed [COORD_BITS-1:0] req_bx_start,
   input  logic signed [COORD_BITS-1:0] req_by_start,
   input  logic signed [COORD_BITS-1:0] req_bx_end,
   input  logic signed [COORD_BITS-1:0] req_by_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_intersects
);

   // stage valid bits and backpressure chain
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, rsp_valid_in;
   logic out_free, s3_free, s2_free, s1_free;
   sit_pkg::lane_en_type en;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s3_free  = !v3_ff || out_free;
   assign s2_free  = !v2_ff || s3_free;
   assign s1_free  = !v1_ff || s2_free;
   assign req_ready = s1_free;

   assign v1_in        = s1_free  ? req_valid : v1_ff;
   assign v2_in        = s2_free  ? v1_ff     : v2_ff;
   assign v3_in        = s3_free  ? v2_ff     : v3_ff;
   assign rsp_valid_in = out_free ? v3_ff     : rsp_valid_ff;

   assign en.s1 = s1_free && req_valid;
   assign en.s2 = s2_free && v1_ff;
   assign en.s3 = s3_free && v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // four lanes: B endpoints against A, then A endpoints against B
   sit_pkg::class_type c1, c2, c3, c4;

   sit_lane #(.COORD_BITS(COORD_BITS)) u_lane_c1 (
      .clock(clock), .en(en),
      .sx(req_ax_start), .sy(req_ay_start), .ex(req_ax_end), .ey(req_ay_end),
      .qx(req_bx_start), .qy(req_by_start), .cls(c1)
   );

   sit_lane #(.COORD_BITS(COORD_BITS)) u_lane_c2 (
      .clock(clock), .en(en),
      .sx(req_ax_start), .sy(req_ay_start), .ex(req_ax_end), .ey(req_ay_end),
      .qx(req_bx_end), .qy(req_by_end), .cls(c2)
   );

   sit_lane #(.COORD_BITS(COORD_BITS)) u_lane_c3 (
      .clock(clock), .en(en),
      .sx(req_bx_start), .sy(req_by_start), .ex(req_bx_end), .ey(req_by_end),
      .qx(req_ax_start), .qy(req_ay_start), .cls(c3)
   );

   sit_lane #(.COORD_BITS(COORD_BITS)) u_lane_c4 (
      .clock(clock), .en(en),
      .sx(req_bx_start), .sy(req_by_start), .ex(req_bx_end), .ey(req_by_end),
      .qx(req_ax_end), .qy(req_ay_end), .cls(c4)
   );

   // combine and output register
   logic hit_in, hit_ff;

   assign hit_in = sit_pkg::pair_ok(c1, c2) && sit_pkg::pair_ok(c3, c4);

   always_ff @(posedge clock) begin
      if (out_free && v3_ff) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_intersects = hit_ff;

   // accepted request always lands in stage 1
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted request not captured in stage 1");

   // a stalled item in the last lane stage is held, not dropped
   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !out_free) |=> v3_ff)
      else $error("stage 3 item lost under output stall");

   // a full pipeline with a stalled output refuses new requests
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted into a full pipeline");

   // with no stall downstream, stage 2 contents move to stage 3
   a_s2_moves: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && s3_free) |=> v3_ff)
      else $error("stage 2 item did not advance");

endmodule

### tb/tb.sv
// Self-checking bench for segment_intersection_test_unit: directed pairs, then random ones.
// Depends on sit_pkg (class_type) and the unit's RTL; it has its own model of the ccw test.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = 16;
   localparam int RANDOM_REQS = 600;
   localparam int BY_MODEL    = -1;     // no typed answer, ask the model
   localparam int BACKLOG_AT  = 220;    // request count that starts the long output stall
   localparam int BACKLOG_LEN = 120;
   localparam int DRAIN_AT    = 450;    // random request index where the sender drains
   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_MAX    = 10;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type ax_start, ay_start, ax_end, ay_end;
      coord_type bx_start, by_start, bx_end, by_end;
   } seg_pair_type;

   typedef struct {
      seg_pair_type pair;
      int           want;
   } table_row_type;

   typedef struct {
      bit hit;
      int tag;
   } hit_entry_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_ax_start, req_ay_start, req_ax_end, req_ay_end;
   coord_type req_bx_start, req_by_start, req_bx_end, req_by_end;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_intersects;

   hit_entry_type pending_hits[$];
   table_row_type corner_rows[$];
   int            accepted_reqs = 0;
   int            mismatches = 0;
   int            cycle_count = 0;
   bit            backlog_done = 1'b0;
   bit            backlog_on = 1'b0;

   segment_intersection_test_unit #(.COORD_BITS(CW)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ax_start   (req_ax_start),
      .req_ay_start   (req_ay_start),
      .req_ax_end     (req_ax_end),
      .req_ay_end     (req_ay_end),
      .req_bx_start   (req_bx_start),
      .req_by_start   (req_by_start),
      .req_bx_end     (req_bx_end),
      .req_by_end     (req_by_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_intersects (rsp_intersects)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic sit_pkg::class_type sign_of(longint v);
      if (v > 0) return sit_pkg::CLS_POS;
      if (v < 0) return sit_pkg::CLS_NEG;
      return sit_pkg::CLS_ZERO;
   endfunction

   // Side of point q against directed segment s->e; collinear points are
   // placed before the start, between the ends, or past the end.
   function automatic sit_pkg::class_type side_of(longint sx, longint sy,
                                                  longint ex, longint ey,
                                                  longint qx, longint qy);
      longint             dx, dy, px, py;
      sit_pkg::class_type side;
      dx = ex - sx;
      dy = ey - sy;
      px = qx - sx;
      py = qy - sy;
      side = sign_of(px * dy - py * dx);
      if (side == sit_pkg::CLS_ZERO) begin
         side = sign_of(px * dx + py * dy);
         if (side == sit_pkg::CLS_POS)
            side = (sign_of((px - dx) * dx + (py - dy) * dy) == sit_pkg::CLS_POS) ?
                   sit_pkg::CLS_POS : sit_pkg::CLS_ZERO;
      end
      return side;
   endfunction

   function automatic bit segments_touch(seg_pair_type p);
      sit_pkg::class_type a_s, a_e, b_s, b_e;
      a_s = side_of(p.ax_start, p.ay_start, p.ax_end, p.ay_end, p.bx_start, p.by_start);
      a_e = side_of(p.ax_start, p.ay_start, p.ax_end, p.ay_end, p.bx_end, p.by_end);
      b_s = side_of(p.bx_start, p.by_start, p.bx_end, p.by_end, p.ax_start, p.ay_start);
      b_e = side_of(p.bx_start, p.by_start, p.bx_end, p.by_end, p.ax_end, p.ay_end);
      // both ends strictly on one side of either segment means no contact
      return !((a_s == a_e && a_s != sit_pkg::CLS_ZERO) ||
               (b_s == b_e && b_s != sit_pkg::CLS_ZERO));
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int rnd(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic seg_pair_type pack_pair(int c[8]);
      seg_pair_type p;
      p.ax_start = c[0][CW-1:0];
      p.ay_start = c[1][CW-1:0];
      p.ax_end   = c[2][CW-1:0];
      p.ay_end   = c[3][CW-1:0];
      p.bx_start = c[4][CW-1:0];
      p.by_start = c[5][CW-1:0];
      p.bx_end   = c[6][CW-1:0];
      p.by_end   = c[7][CW-1:0];
      return p;
   endfunction

   function automatic void add_row(int ax0, int ay0, int ax1, int ay1,
                                   int bx0, int by0, int bx1, int by1, int want);
      table_row_type row;
      int            c[8];
      c = '{ax0, ay0, ax1, ay1, bx0, by0, bx1, by1};
      row.pair = pack_pair(c);
      row.want = want;
      corner_rows.push_back(row);
   endfunction

   // Mostly no idle, often a short one, now and then a long one
   function automatic int idle_len();
      int pick;
      pick = rnd(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return rnd(1, 3);
      return rnd(8, 40);
   endfunction

   function automatic seg_pair_type random_pair();
      int c[8];
      int mode, ox, oy, dx, dy, j, m;
      mode = rnd(0, 99);
      foreach (c[k]) c[k] = rnd(-512, 511);
      if (mode < 15) begin
         // full coordinate range, every bit pattern
         foreach (c[k]) c[k] = int'($urandom());
      end else if (mode < 32) begin
         // all four points on one line, at integer steps of a common direction
         ox = rnd(-4096, 4095);
         oy = rnd(-4096, 4095);
         dx = rnd(-256, 256);
         dy = rnd(-256, 256);
         for (int k = 0; k < 4; k++) begin
            j = rnd(-4, 4);
            c[2*k]   = ox + j * dx;
            c[2*k+1] = oy + j * dy;
         end
      end else if (mode < 44) begin
         // one endpoint shared between the segments
         j = 2 * rnd(0, 1);
         m = 4 + 2 * rnd(0, 1);
         c[m]   = c[j];
         c[m+1] = c[j+1];
      end else if (mode < 54) begin
         // degenerate segment(s) of zero length
         j = 4 * rnd(0, 1);
         c[j+2] = c[j];
         c[j+3] = c[j+1];
         if (rnd(0, 3) == 0) begin
            c[6] = c[4];
            c[7] = c[5];
         end
      end else if (mode < 70) begin
         // coarse grid: lots of touching, T-junctions and overlaps
         foreach (c[k]) c[k] = 256 * rnd(-4, 4);
      end
      return pack_pair(c);
   endfunction

   // Present one request and hold it until the unit takes it
   task automatic offer_pair(seg_pair_type p, int want);
      hit_entry_type e;
      req_ax_start <= p.ax_start;
      req_ay_start <= p.ay_start;
      req_ax_end   <= p.ax_end;
      req_ay_end   <= p.ay_end;
      req_bx_start <= p.bx_start;
      req_by_start <= p.by_start;
      req_bx_end   <= p.bx_end;
      req_by_end   <= p.by_end;
      req_valid    <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      e.hit = (want == BY_MODEL) ? segments_touch(p) : want[0];
      e.tag = accepted_reqs;
      pending_hits.push_back(e);
      accepted_reqs++;
      @(negedge clock);
   endtask

   task automatic sender_idle(int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic note_mismatch(string what, int tag, logic want, logic got);
      mismatches++;
      if (mismatches <= SHOW_MAX)
         $display("MISMATCH %s request %0d: expected intersects=%b, got %b",
                  what, tag, want, got);
   endtask

   // ---------------------------------------------------------------- main flow

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      rsp_ready    = 1'b0;
      req_ax_start = '0;
      req_ay_start = '0;
      req_ax_end   = '0;
      req_ay_end   = '0;
      req_bx_start = '0;
      req_by_start = '0;
      req_bx_end   = '0;
      req_by_end   = '0;

      // Corner cases: crossing, parallel, touching, collinear, degenerate, extremes
      add_row(0, 0, 256, 256, 0, 256, 256, 0, 1);                 // plain X crossing
      add_row(0, 0, 256, 0, 0, 256, 256, 256, 0);                 // parallel, apart
      add_row(0, 0, 256, 0, 256, 0, 512, 256, 1);                 // shared endpoint
      add_row(0, 0, 512, 0, 256, 0, 768, 0, 1);                   // collinear overlap
      add_row(0, 0, 256, 0, 512, 0, 768, 0, 0);                   // collinear, beyond end
      add_row(0, 0, 256, 0, -768, 0, -512, 0, 0);                 // collinear, before start
      add_row(0, 0, 256, 0, 512, 0, 256, 0, 1);                   // collinear, end to end
      add_row(0, -256, 0, 256, 0, 0, 0, 512, 1);                  // vertical overlap
      add_row(0, 0, 256, 0, 0, 0, 256, 0, 1);                     // identical segments
      add_row(0, 0, 512, 0, 256, 256, 256, 0, 1);                 // T-junction
      add_row(0, 0, 512, 0, 256, 256, 256, 1, 0);                 // near miss by one lsb
      add_row(0, 0, 256, 0, 512, -256, 512, 256, 0);              // lines cross off segment
      add_row(128, 0, 128, 0, 0, 0, 256, 0, 1);                   // point on segment
      add_row(128, 128, 128, 128, 0, 0, 256, 0, 0);               // point off segment
      add_row(64, 64, 64, 64, 64, 64, 64, 64, 1);                 // two equal points
      add_row(64, 64, 64, 64, -64, 32, -64, 32, 1);               // two distinct points
      add_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1);
      add_row(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, 0);
      add_row(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 1);
      add_row(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, 1);
      add_row(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 1);
      add_row(21845, -21846, -21846, 21845, -1, 0, 0, -1, BY_MODEL);
      add_row(-1, -1, 1, 1, 1, -1, -1, 1, BY_MODEL);
      add_row(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768, BY_MODEL);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (corner_rows[i]) begin
         offer_pair(corner_rows[i].pair, corner_rows[i].want);
         sender_idle(idle_len());
      end

      for (int i = 0; i < RANDOM_REQS; i++) begin
         offer_pair(random_pair(), BY_MODEL);
         if (i == DRAIN_AT) begin
            // sender pauses until everything in flight has come back
            req_valid <= 1'b0;
            while (pending_hits.size() != 0) @(posedge clock);
            @(negedge clock);
         end else if (!backlog_on) begin
            sender_idle(idle_len());
         end
      end
      req_valid <= 1'b0;

      while (pending_hits.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("segment_intersection_test_unit verification clean");
      else
         $display("segment_intersection_test_unit verification failed");
      $finish;
   end

   // Output side: ready toggles in runs; one long hold-off fills the pipeline
   initial begin
      int run, gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!backlog_done && accepted_reqs >= BACKLOG_AT) begin
            backlog_on = 1'b1;
            rsp_ready <= 1'b0;
            repeat (BACKLOG_LEN) @(negedge clock);
            backlog_on   = 1'b0;
            backlog_done = 1'b1;
         end else begin
            run = rnd(1, 24);
            gap = idle_len();
            if (!rsp_ready) rsp_ready <= 1'b1;
            repeat (run) @(negedge clock);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin
      hit_entry_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hits.size() == 0) begin
            note_mismatch("unexpected result after", accepted_reqs, 1'bx, rsp_intersects);
         end else begin
            e = pending_hits.pop_front();
            if (rsp_intersects !== e.hit)
               note_mismatch("on", e.tag, e.hit, rsp_intersects);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("segment_intersection_test_unit verification failed");
         $finish;
      end
   end

endmodule
